// ===== rtl/charge_current_pd_regulator_unit_assert.svh =====
// Assertion macros shared by the regulator RTL.
`ifndef CHARGE_CURRENT_PD_REGULATOR_UNIT_ASSERT_SVH
`define CHARGE_CURRENT_PD_REGULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CCPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccpd assertion failed");

// Next-cycle implication, disabled while in reset.
`define CCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccpd assertion failed");

`endif

// ===== rtl/ccpd_pkg.sv =====
// Types and constants shared by the PD regulator modules.
package ccpd_pkg;

    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 3;
    // kp*err + kd*derr needs 33 bits signed; one spare
    localparam int ACC_W     = 34;
    localparam int MUL_BITS  = 17;
    localparam int MUL_CNT_W = 5;

    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_BITS - 1);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_MV     = 3'd5;

    localparam logic [DATA_W-1:0]        RST_TARGET_MV  = 16'd5000;
    localparam logic signed [DATA_W-1:0] RST_GAIN_P     = 16'sd256;
    localparam logic signed [DATA_W-1:0] RST_GAIN_D     = 16'sd0;
    localparam logic [DATA_W-1:0]        RST_PWM_PERIOD = 16'd1000;
    localparam logic [DATA_W-1:0]        RST_SUPPLY_MV  = 16'd3300;

    localparam logic signed [DATA_W-1:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAT_NEG = 16'sh8000;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_MUL     = 7'b0000010,
        S_CORR    = 7'b0000100,
        S_DRV     = 7'b0001000,
        S_CMPGO   = 7'b0010000,
        S_CMPWAIT = 7'b0100000,
        S_DONE    = 7'b1000000
    } ccpd_state_t;

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_MUL   = 4'b0010,
        C_CHECK = 4'b0100,
        C_DIV   = 4'b1000
    } ccpd_cmp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ccpd_cmp_status_t;

endpackage

// ===== rtl/ccpd_cmp_unit.sv =====
// Serial PWM compare unit: period*drive by shift-add, then restoring divide by supply.
`include "charge_current_pd_regulator_unit_assert.svh"

module ccpd_cmp_unit
    import ccpd_pkg::*;
#(
    parameter int DRIVE_W = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DATA_W-1:0]   period,
    input  logic [DATA_W-1:0]   supply,
    input  logic [DRIVE_W-1:0]  drive,
    output logic [DATA_W-1:0]   quotient,
    output ccpd_cmp_status_t    status
);

    localparam int NUM_W = DATA_W + DRIVE_W;
    localparam int CW    = (NUM_W > 2 * DATA_W) ? NUM_W : 2 * DATA_W;
    localparam int CNT_W = $clog2(((DRIVE_W > DATA_W) ? DRIVE_W : DATA_W) + 1);

    localparam logic [CNT_W-1:0] MUL_END = CNT_W'(DRIVE_W - 1);
    localparam logic [CNT_W-1:0] DIV_END = CNT_W'(DATA_W - 1);

    ccpd_cmp_state_t     state_reg, state_next;
    logic [NUM_W-1:0]    mcand_reg, mcand_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [DRIVE_W-1:0]  drv_sh_reg, drv_sh_next;
    logic [DATA_W-1:0]   sup_reg, sup_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;

    logic [CW-1:0]       num_ext;
    logic [CW-1:0]       lim_ext;
    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     trial;

    always_comb
    begin
        num_ext = CW'(num_reg);
        lim_ext = CW'({sup_reg, {DATA_W{1'b0}}});
        shifted = {rem_reg, q_reg[DATA_W-1]};
        trial   = shifted - {1'b0, sup_reg};
    end

    always_comb
    begin
        state_next  = state_reg;
        mcand_next  = mcand_reg;
        num_next    = num_reg;
        drv_sh_next = drv_sh_reg;
        sup_next    = sup_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    mcand_next  = NUM_W'(period);
                    drv_sh_next = drive;
                    sup_next    = supply;
                    num_next    = '0;
                    cnt_next    = '0;
                    state_next  = C_MUL;
                end
            end
            C_MUL:
            begin
                num_next    = num_reg + (drv_sh_reg[0] ? mcand_reg : '0);
                mcand_next  = mcand_reg << 1;
                drv_sh_next = drv_sh_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MUL_END)
                begin
                    state_next = C_CHECK;
                end
            end
            C_CHECK:
            begin
                cnt_next = '0;
                if (num_reg == '0)
                begin
                    q_next     = '0;
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else if (num_ext >= lim_ext)
                begin
                    // quotient would not fit (or supply is zero)
                    q_next     = '1;
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else
                begin
                    rem_next   = num_ext[2*DATA_W-1:DATA_W];
                    q_next     = num_ext[DATA_W-1:0];
                    state_next = C_DIV;
                end
            end
            C_DIV:
            begin
                if (!trial[DATA_W])
                begin
                    rem_next = trial[DATA_W-1:0];
                    q_next   = {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[DATA_W-1:0];
                    q_next   = {q_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_END)
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        num_reg    <= num_next;
        drv_sh_reg <= drv_sh_next;
        sup_reg    <= sup_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
    end

    assign quotient    = q_reg;
    assign status.busy = (state_reg != C_IDLE);
    assign status.done = done_reg;

    `CCPD_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `CCPD_ASSERT_IMPL(a_rem_below_supply, clk, rst_n, state_reg == C_DIV, rem_reg < sup_reg)
    `CCPD_ASSERT_IMPL(a_mul_count, clk, rst_n, state_reg == C_MUL, cnt_reg <= MUL_END)

endmodule

// ===== rtl/charge_current_pd_regulator_unit.sv =====
// Top level of the incremental PD drive regulator with PWM compare output.
// One voltage sample word in, one result word out. With output enabled a sample
// runs through the bit-serial PD multiply, then the serial period*drive multiply
// and the restoring divide by supply in the compare unit, plus control steps;
// with output disabled a word skips both and returns zero correction and compare.
// One sample is in work at a time; the next is taken as soon as the previous
// result sits in the output register. Configuration writes are always ready and
// should only be made while the block is idle.
`include "charge_current_pd_regulator_unit_assert.svh"

module charge_current_pd_regulator_unit
    import ccpd_pkg::*;
#(
    parameter int DRIVE_MAX      = 1500,
    parameter int GAIN_FRAC_BITS = 8,
    localparam int DRIVE_W       = $clog2(DRIVE_MAX + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // sample channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [DATA_W-1:0]          sample_mv,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [DATA_W-1:0]          compare_count,
    output logic [DRIVE_W-1:0]         drive_mv,
    output logic signed [DATA_W-1:0]   correction,
    // configuration channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DATA_W-1:0]          cfg_data
);

    localparam int DIFF_W = ((DRIVE_W > DATA_W) ? DRIVE_W : DATA_W) + 2;

    // configuration
    logic                        en_reg;
    logic [DATA_W-1:0]           target_reg;
    logic signed [DATA_W-1:0]    kp_reg;
    logic signed [DATA_W-1:0]    kd_reg;
    logic [DATA_W-1:0]           period_reg;
    logic [DATA_W-1:0]           supply_reg;

    // regulator state
    logic signed [DATA_W-1:0]    prev_err_reg, prev_err_next;
    logic [DRIVE_W-1:0]          drive_level_reg, drive_level_next;

    // work in progress
    ccpd_state_t                 state_reg, state_next;
    logic [MUL_BITS-1:0]         err_sh_reg, err_sh_next;
    logic [MUL_BITS-1:0]         derr_sh_reg, derr_sh_next;
    logic signed [ACC_W-1:0]     kp_sh_reg, kp_sh_next;
    logic signed [ACC_W-1:0]     kd_sh_reg, kd_sh_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic [MUL_CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic signed [DATA_W-1:0]    corr_reg, corr_next;
    logic [DATA_W-1:0]           res_cmp_reg, res_cmp_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]           compare_count_reg;
    logic [DRIVE_W-1:0]          drive_mv_reg;
    logic signed [DATA_W-1:0]    correction_reg;

    logic                        in_acc;
    logic                        out_load;
    logic                        cmp_start;
    logic [DATA_W-1:0]           cmp_quot;
    ccpd_cmp_status_t            cmp_status;

    logic signed [DATA_W:0]      err_diff;
    logic signed [DATA_W-1:0]    err_sat;
    logic signed [MUL_BITS-1:0]  derr;
    logic signed [ACC_W-1:0]     term_p;
    logic signed [ACC_W-1:0]     term_d;
    logic signed [ACC_W-1:0]     acc_step;
    logic [ACC_W-1:0]            mag;
    logic [ACC_W-1:0]            mag_sh;
    logic [ACC_W-1:0]            mag_neg;
    logic signed [DATA_W-1:0]    corr_sat;
    logic signed [DIFF_W-1:0]    drv_diff;
    logic [DRIVE_W-1:0]          drv_clamp;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign cmp_start = (state_reg == S_CMPGO);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= 1'b0;
            target_reg <= RST_TARGET_MV;
            kp_reg     <= RST_GAIN_P;
            kd_reg     <= RST_GAIN_D;
            period_reg <= RST_PWM_PERIOD;
            supply_reg <= RST_SUPPLY_MV;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OUTPUT_ENABLE: en_reg     <= cfg_data[0];
                REG_TARGET_MV:     target_reg <= cfg_data;
                REG_GAIN_P:        kp_reg     <= signed'(cfg_data);
                REG_GAIN_D:        kd_reg     <= signed'(cfg_data);
                REG_PWM_PERIOD:    period_reg <= cfg_data;
                REG_SUPPLY_MV:     supply_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // error saturated to 16 bits, and its 17-bit difference from the previous error
    always_comb
    begin
        err_diff = signed'({1'b0, sample_mv}) - signed'({1'b0, target_reg});
        if (err_diff > 17'sd32767)
        begin
            err_sat = SAT_POS;
        end
        else if (err_diff < -17'sd32768)
        begin
            err_sat = SAT_NEG;
        end
        else
        begin
            err_sat = err_diff[DATA_W-1:0];
        end
        derr = MUL_BITS'(err_sat) - MUL_BITS'(prev_err_reg);
    end

    // one multiplier bit per cycle for both products; top bit carries negative weight
    always_comb
    begin
        term_p = err_sh_reg[0]  ? kp_sh_reg : '0;
        term_d = derr_sh_reg[0] ? kd_sh_reg : '0;
        if (bit_cnt_reg == MUL_LAST)
        begin
            acc_step = acc_reg - term_p - term_d;
        end
        else
        begin
            acc_step = acc_reg + term_p + term_d;
        end
    end

    // scale back by the gain fraction, truncating toward zero, then saturate to 16 bits
    always_comb
    begin
        mag     = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        mag_sh  = mag >> GAIN_FRAC_BITS;
        mag_neg = ~mag_sh + 1'b1;
        if (acc_reg[ACC_W-1])
        begin
            corr_sat = (mag_sh > ACC_W'(32768)) ? SAT_NEG : signed'(mag_neg[DATA_W-1:0]);
        end
        else
        begin
            corr_sat = (mag_sh > ACC_W'(32767)) ? SAT_POS : signed'(mag_sh[DATA_W-1:0]);
        end
    end

    always_comb
    begin
        drv_diff = signed'(DIFF_W'(drive_level_reg)) - DIFF_W'(corr_reg);
        if (drv_diff < 0)
        begin
            drv_clamp = '0;
        end
        else if (drv_diff > DIFF_W'(DRIVE_MAX))
        begin
            drv_clamp = DRIVE_W'(DRIVE_MAX);
        end
        else
        begin
            drv_clamp = drv_diff[DRIVE_W-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        err_sh_next      = err_sh_reg;
        derr_sh_next     = derr_sh_reg;
        kp_sh_next       = kp_sh_reg;
        kd_sh_next       = kd_sh_reg;
        acc_next         = acc_reg;
        bit_cnt_next     = bit_cnt_reg;
        corr_next        = corr_reg;
        res_cmp_next     = res_cmp_reg;
        prev_err_next    = prev_err_reg;
        drive_level_next = drive_level_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!en_reg)
                    begin
                        corr_next    = '0;
                        res_cmp_next = '0;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        err_sh_next   = MUL_BITS'(err_sat);
                        derr_sh_next  = derr;
                        kp_sh_next    = ACC_W'(kp_reg);
                        kd_sh_next    = ACC_W'(kd_reg);
                        acc_next      = '0;
                        bit_cnt_next  = '0;
                        prev_err_next = err_sat;
                        state_next    = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                acc_next     = acc_step;
                err_sh_next  = err_sh_reg >> 1;
                derr_sh_next = derr_sh_reg >> 1;
                kp_sh_next   = kp_sh_reg <<< 1;
                kd_sh_next   = kd_sh_reg <<< 1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == MUL_LAST)
                begin
                    state_next = S_CORR;
                end
            end
            S_CORR:
            begin
                corr_next  = corr_sat;
                state_next = S_DRV;
            end
            S_DRV:
            begin
                drive_level_next = drv_clamp;
                state_next       = S_CMPGO;
            end
            S_CMPGO:
            begin
                state_next = S_CMPWAIT;
            end
            S_CMPWAIT:
            begin
                if (cmp_status.done)
                begin
                    res_cmp_next = cmp_quot;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bit_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            prev_err_reg    <= '0;
            drive_level_reg <= DRIVE_W'(DRIVE_MAX);
        end
        else
        begin
            state_reg       <= state_next;
            bit_cnt_reg     <= bit_cnt_next;
            out_valid_reg   <= out_valid_next;
            prev_err_reg    <= prev_err_next;
            drive_level_reg <= drive_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_sh_reg  <= err_sh_next;
        derr_sh_reg <= derr_sh_next;
        kp_sh_reg   <= kp_sh_next;
        kd_sh_reg   <= kd_sh_next;
        acc_reg     <= acc_next;
        corr_reg    <= corr_next;
        res_cmp_reg <= res_cmp_next;
        if (out_load)
        begin
            compare_count_reg <= res_cmp_reg;
            drive_mv_reg      <= drive_level_reg;
            correction_reg    <= corr_reg;
        end
    end

    ccpd_cmp_unit #(
        .DRIVE_W (DRIVE_W)
    ) u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmp_start),
        .period   (period_reg),
        .supply   (supply_reg),
        .drive    (drive_level_reg),
        .quotient (cmp_quot),
        .status   (cmp_status)
    );

    assign out_valid     = out_valid_reg;
    assign compare_count = compare_count_reg;
    assign drive_mv      = drive_mv_reg;
    assign correction    = correction_reg;

    `CCPD_ASSERT_IMPL(a_drive_bound, clk, rst_n, 1'b1, drive_level_reg <= DRIVE_W'(DRIVE_MAX))
    `CCPD_ASSERT_IMPL(a_start_idle, clk, rst_n, cmp_start, !cmp_status.busy)
    `CCPD_ASSERT_IMPL(a_mul_count, clk, rst_n, state_reg == S_MUL, bit_cnt_reg <= MUL_LAST)
    `CCPD_ASSERT_NEXT(a_disabled_hold, clk, rst_n, in_acc && !en_reg, prev_err_reg == $past(prev_err_reg) && drive_level_reg == $past(drive_level_reg))

endmodule

// ===== verif/tb_charge_current_pd_regulator_unit.sv =====
// Self-checking testbench for the PD drive regulator: directed table, then random samples.
module tb_charge_current_pd_regulator_unit
    import ccpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRIVE_LIMIT  = 1500;
    localparam int DRIVE_BITS   = 11;
    localparam int FRAC_BITS    = 8;
    localparam int SETTLE_WAIT  = 64;
    localparam int STALL_LIMIT  = 5000;   // cycles with no word moving on any channel
    localparam int PHASES       = 4;
    localparam int BLOCKS       = 5;
    localparam int BLOCK_ITEMS  = 100;

    typedef struct packed {
        logic [DATA_W-1:0]     cmp;
        logic [DRIVE_BITS-1:0] drv;
        logic [DATA_W-1:0]     corr;
    } pd_result_t;

    typedef enum logic [0:0] {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]   data;
        logic                known;
        pd_result_t          res;
    } stim_row_t;

    typedef struct packed {
        logic       known;
        pd_result_t res;
    } sample_tag_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [DATA_W-1:0]        sample_mv;
    logic                     out_valid;
    logic                     out_stall;
    logic [DATA_W-1:0]        compare_count;
    logic [DRIVE_BITS-1:0]    drive_mv;
    logic signed [DATA_W-1:0] correction;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    sample_tag_t sample_tag;

    // mirror of the block's registers and state
    logic                     m_enable;
    logic [DATA_W-1:0]        m_target;
    logic signed [DATA_W-1:0] m_gain_p;
    logic signed [DATA_W-1:0] m_gain_d;
    logic [DATA_W-1:0]        m_period;
    logic [DATA_W-1:0]        m_supply;
    logic signed [DATA_W-1:0] m_prev_err;
    logic [DRIVE_BITS-1:0]    m_drive;

    pd_result_t pending_results[$];
    stim_row_t  dir_rows[$];

    int err_count;
    int items_sent;
    int results_seen;
    int idle_cycles;
    int gap_pct;
    int stall_pct;
    int settings_used;
    int disabled_seen;
    int saturated_seen;

    pd_result_t mon_got;
    pd_result_t mon_want;
    pd_result_t mon_pred;
    logic       mon_moved;

    charge_current_pd_regulator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_mv     (sample_mv),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .compare_count (compare_count),
        .drive_mv      (drive_mv),
        .correction    (correction),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint sat16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic pd_result_t pd_predict(input logic [DATA_W-1:0] smp);
        pd_result_t r;
        longint err;
        longint derr;
        longint sum;
        longint mag;
        longint corr;
        longint drv;
        longint num;
        longint q;
        r = '0;
        if (!m_enable)
        begin
            r.drv = m_drive;
            return r;
        end
        err  = sat16(longint'(smp) - longint'(m_target));
        derr = err - longint'(m_prev_err);
        m_prev_err = err[DATA_W-1:0];
        sum  = longint'(m_gain_p) * err + longint'(m_gain_d) * derr;
        mag  = (sum < 0) ? -sum : sum;
        mag  = mag >> FRAC_BITS;    // truncates toward zero on the magnitude
        corr = sat16((sum < 0) ? -mag : mag);
        drv  = longint'(m_drive) - corr;
        if (drv < 0)
            drv = 0;
        if (drv > DRIVE_LIMIT)
            drv = DRIVE_LIMIT;
        m_drive = drv[DRIVE_BITS-1:0];
        num = longint'(m_period) * drv;
        if (num == 0)
            r.cmp = '0;
        else if (m_supply == '0)
            r.cmp = '1;
        else
        begin
            q = num / longint'(m_supply);
            r.cmp = (q > 65535) ? 16'hFFFF : q[DATA_W-1:0];
        end
        r.drv  = m_drive;
        r.corr = corr[DATA_W-1:0];
        return r;
    endfunction

    function automatic void mirror_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [DATA_W-1:0] data);
        case (idx)
            REG_OUTPUT_ENABLE: m_enable = data[0];
            REG_TARGET_MV:     m_target = data;
            REG_GAIN_P:        m_gain_p = data;
            REG_GAIN_D:        m_gain_d = data;
            REG_PWM_PERIOD:    m_period = data;
            REG_SUPPLY_MV:     m_supply = data;
            default:           ;
        endcase
    endfunction

    function automatic stim_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] data);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic stim_row_t row_sample(input logic [DATA_W-1:0] data);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_SAMPLE;
        r.data = data;
        return r;
    endfunction

    function automatic stim_row_t row_known(input logic [DATA_W-1:0] data,
                                            input logic [DATA_W-1:0] cmp,
                                            input logic [DRIVE_BITS-1:0] drv,
                                            input logic [DATA_W-1:0] corr);
        stim_row_t r;
        r          = row_sample(data);
        r.known    = 1'b1;
        r.res.cmp  = cmp;
        r.res.drv  = drv;
        r.res.corr = corr;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_extreme16();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch %s: got %h want %h at result %0d", what, got, want,
                 results_seen);
        err_count++;
    endtask

    // caller sits on a rising edge; returns on the edge where the word was taken
    task automatic send_sample(input logic [DATA_W-1:0] data, input logic known,
                               input pd_result_t res);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        sample_mv        <= data;
        sample_tag.known <= known;
        sample_tag.res   <= res;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // sender holds off until every result is back, then lets the pipe settle
    task automatic wait_results_settled();
        in_valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic random_setting();
        int g;
        wait_results_settled();
        settings_used++;
        write_reg(REG_OUTPUT_ENABLE, ($urandom_range(0, 99) < 85) ? 16'd1 : 16'd0);
        if ($urandom_range(0, 9) < 8)
            write_reg(REG_TARGET_MV, 16'($urandom_range(3000, 7000)));
        else
            write_reg(REG_TARGET_MV, ($urandom_range(0, 1) == 0) ? pick_extreme16()
                                                                 : 16'($urandom()));
        g = int'($urandom_range(0, 1200)) - 600;
        write_reg(REG_GAIN_P, ($urandom_range(0, 9) < 2) ? pick_extreme16() : g[DATA_W-1:0]);
        g = int'($urandom_range(0, 1200)) - 600;
        write_reg(REG_GAIN_D, ($urandom_range(0, 9) < 2) ? pick_extreme16() : g[DATA_W-1:0]);
        write_reg(REG_PWM_PERIOD, ($urandom_range(0, 9) < 2) ? pick_extreme16()
                                                             : 16'($urandom_range(1, 2000)));
        write_reg(REG_SUPPLY_MV, ($urandom_range(0, 9) < 2) ? pick_extreme16()
                                                            : 16'($urandom_range(1000, 5000)));
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            mon_moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                mirror_cfg(cfg_index, cfg_data);
                mon_moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                mon_moved = 1'b1;
                mon_got.cmp  = compare_count;
                mon_got.drv  = drive_mv;
                mon_got.corr = correction;
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result word", compare_count, '0);
                else
                begin
                    mon_want = pending_results.pop_front();
                    if (mon_got.cmp !== mon_want.cmp)
                        report_mismatch("compare_count", mon_got.cmp, mon_want.cmp);
                    if (mon_got.drv !== mon_want.drv)
                        report_mismatch("drive_mv", DATA_W'(mon_got.drv), DATA_W'(mon_want.drv));
                    if (mon_got.corr !== mon_want.corr)
                        report_mismatch("correction", mon_got.corr, mon_want.corr);
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
            begin
                mon_moved = 1'b1;
                if (!m_enable)
                    disabled_seen++;
                mon_pred = pd_predict(sample_mv);
                if (m_enable && (mon_pred.corr == SAT_POS || mon_pred.corr == SAT_NEG))
                    saturated_seen++;
                pending_results.push_back(sample_tag.known ? sample_tag.res : mon_pred);
            end
            idle_cycles = mon_moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int delta;
        int s;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample_mv  = '0;
        sample_tag = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        gap_pct    = 0;
        stall_pct  = 0;
        err_count      = 0;
        items_sent     = 0;
        results_seen   = 0;
        idle_cycles    = 0;
        settings_used  = 0;
        disabled_seen  = 0;
        saturated_seen = 0;
        m_enable   = 1'b0;
        m_target   = RST_TARGET_MV;
        m_gain_p   = RST_GAIN_P;
        m_gain_d   = RST_GAIN_D;
        m_period   = RST_PWM_PERIOD;
        m_supply   = RST_SUPPLY_MV;
        m_prev_err = '0;
        m_drive    = DRIVE_BITS'(DRIVE_LIMIT);

        // output disabled out of reset
        dir_rows.push_back(row_known(16'd0,     16'd0, 11'd1500, 16'd0));
        dir_rows.push_back(row_known(16'hFFFF,  16'd0, 11'd1500, 16'd0));
        dir_rows.push_back(row_write(REG_OUTPUT_ENABLE, 16'd1));
        // reset gains: correction equals the error
        dir_rows.push_back(row_known(16'd5000,  16'd454, 11'd1500, 16'd0));
        dir_rows.push_back(row_known(16'hFFFF,  16'd0,   11'd0,    16'h7FFF));
        dir_rows.push_back(row_known(16'd0,     16'd454, 11'd1500, 16'hEC78));
        // supply zero saturates the compare
        dir_rows.push_back(row_write(REG_SUPPLY_MV, 16'd0));
        dir_rows.push_back(row_known(16'd5000,  16'hFFFF, 11'd1500, 16'd0));
        // period zero gives a zero compare
        dir_rows.push_back(row_write(REG_PWM_PERIOD, 16'd0));
        dir_rows.push_back(row_known(16'd5000,  16'd0, 11'd1500, 16'd0));
        dir_rows.push_back(row_write(REG_PWM_PERIOD, 16'hFFFF));
        dir_rows.push_back(row_write(REG_SUPPLY_MV, 16'd1));
        dir_rows.push_back(row_known(16'd5000,  16'hFFFF, 11'd1500, 16'd0));
        dir_rows.push_back(row_write(REG_SUPPLY_MV, 16'hFFFF));
        dir_rows.push_back(row_known(16'd5000,  16'd1500, 11'd1500, 16'd0));
        // supply zero with drive at zero
        dir_rows.push_back(row_write(REG_PWM_PERIOD, 16'd1000));
        dir_rows.push_back(row_write(REG_SUPPLY_MV, 16'd0));
        dir_rows.push_back(row_known(16'hFFFF,  16'd0,    11'd0,    16'h7FFF));
        dir_rows.push_back(row_known(16'd0,     16'hFFFF, 11'd1500, 16'hEC78));
        // gain extremes, error saturating both ways
        dir_rows.push_back(row_write(REG_SUPPLY_MV, 16'd3300));
        dir_rows.push_back(row_write(REG_GAIN_P, 16'h8000));
        dir_rows.push_back(row_write(REG_GAIN_D, 16'h7FFF));
        dir_rows.push_back(row_write(REG_TARGET_MV, 16'd0));
        dir_rows.push_back(row_sample(16'hFFFF));
        dir_rows.push_back(row_sample(16'd0));
        dir_rows.push_back(row_sample(16'h5555));
        dir_rows.push_back(row_write(REG_TARGET_MV, 16'hFFFF));
        dir_rows.push_back(row_sample(16'd0));
        dir_rows.push_back(row_write(REG_GAIN_P, 16'h7FFF));
        dir_rows.push_back(row_write(REG_GAIN_D, 16'h8000));
        dir_rows.push_back(row_sample(16'hAAAA));
        dir_rows.push_back(row_sample(16'd0));
        dir_rows.push_back(row_sample(16'hFFFF));
        // disabled again: state must hold
        dir_rows.push_back(row_write(REG_OUTPUT_ENABLE, 16'd0));
        dir_rows.push_back(row_sample(16'h1234));
        dir_rows.push_back(row_write(REG_OUTPUT_ENABLE, 16'd1));
        dir_rows.push_back(row_sample(16'h8000));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
            begin
                wait_results_settled();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
                send_sample(dir_rows[i].data, dir_rows[i].known, dir_rows[i].res);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 75; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 75; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase
            for (int b = 0; b < BLOCKS; b++)
            begin
                random_setting();
                for (int n = 0; n < BLOCK_ITEMS; n++)
                begin
                    if ($urandom_range(0, 9) < 7)
                    begin
                        // near the target so the loop actually regulates
                        delta = int'($urandom_range(0, 600)) - 300;
                        s = int'(m_target) + delta;
                        if (s < 0)
                            s = 0;
                        if (s > 65535)
                            s = 65535;
                        send_sample(s[DATA_W-1:0], 1'b0, '0);
                    end
                    else
                        send_sample(16'($urandom()), 1'b0, '0);
                end
            end
        end

        gap_pct = 0;
        wait_results_settled();
        stall_pct = 0;
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 16'(pending_results.size()), '0);

        $display("%0d samples checked over %0d random register settings plus the directed table",
                 results_seen, settings_used);
        $display("%0d samples with output off, %0d with a saturated correction",
                 disabled_seen, saturated_seen);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
